// ===== rtl/core/mks_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI key-split router package
// Shared types, register indexes, status codes and helpers for the router.
// ----------------------------------------------------------------------------
package mks_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_CHANNEL_FILTER  = 3'd0;
  localparam logic [2:0] CFG_SPLIT_KEY       = 3'd1;
  localparam logic [2:0] CFG_LOWER_CHANNEL   = 3'd2;
  localparam logic [2:0] CFG_LOWER_TRANSPOSE = 3'd3;
  localparam logic [2:0] CFG_UPPER_CHANNEL   = 3'd4;
  localparam logic [2:0] CFG_UPPER_TRANSPOSE = 3'd5;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned KeyW     = 7;

  // Status nibbles of the handled message types
  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_PRES = 4'hA;

  localparam logic [1:0] LEN_FULL = 2'd3;

  // Reset values of the configuration registers
  localparam logic [4:0] RST_CHANNEL_FILTER = 5'd0;
  localparam logic [6:0] RST_SPLIT_KEY      = 7'd48;
  localparam logic [4:0] RST_LOWER_CHANNEL  = 5'd1;
  localparam logic [4:0] RST_UPPER_CHANNEL  = 5'd2;
  localparam logic [6:0] RST_TRANSPOSE      = 7'd0;

  localparam logic [KeyW-1:0] KEY_MAX = 7'h7F;
  localparam logic [KeyW-1:0] KEY_MIN = 7'h00;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_ON,
    OP_OFF,
    OP_POLY
  } op_e;

  // One classified message travelling from front to back
  typedef struct packed {
    logic [31:0]       time_stamp;
    logic [7:0]        status;
    logic [7:0]        first;
    logic [7:0]        second;
    logic [1:0]        length;
    op_e               op;
    logic [KeyW-1:0]   key;
    logic signed [6:0] transpose;
  } item_t;

  // One finished result
  typedef struct packed {
    logic [31:0] time_stamp;
    logic [7:0]  status;
    logic [7:0]  first;
    logic [7:0]  second;
    logic [1:0]  length;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Map a 1-based channel register onto a status channel nibble, clamped
  function automatic logic [3:0] chan_nibble(input logic [4:0] c);
    logic [3:0] n;
    if (c == 5'd0) begin
      n = 4'd0;
    end else if (c > 5'd16) begin
      n = 4'd15;
    end else begin
      n = 4'(c - 5'd1);
    end
    return n;
  endfunction

  // Add a signed offset to a key and clamp the result to 0..127
  function automatic logic [KeyW-1:0] shift_clamp(input logic [KeyW-1:0] key,
                                                  input logic signed [6:0] ofs);
    logic [8:0]      sum;
    logic [KeyW-1:0] k;
    sum = {2'b00, key} + {{2{ofs[6]}}, ofs};
    if (sum[8]) begin
      k = KEY_MIN;
    end else if (sum[7]) begin
      k = KEY_MAX;
    end else begin
      k = sum[6:0];
    end
    return k;
  endfunction

endpackage

// ===== rtl/core/mks_front.sv =====
// ----------------------------------------------------------------------------
// MIDI key-split router front end
// Holds the configuration registers, accepts messages and classifies them
// into pass-through or note operations with zone channel and transpose.
// ----------------------------------------------------------------------------
module mks_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mks_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mks_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [31:0]                 time_stamp_i,
  input  logic [7:0]                  status_byte_i,
  input  logic [7:0]                  first_data_i,
  input  logic [7:0]                  second_data_i,
  input  logic [1:0]                  msg_length_i,
  input  mks_pkg::qstat_t             q_stat_i,
  output logic                        push_o,
  output mks_pkg::item_t              item_o
);
  import mks_pkg::*;

  logic [4:0]        channel_filter_q;
  logic [6:0]        split_key_q;
  logic [4:0]        lower_channel_q;
  logic signed [6:0] lower_transpose_q;
  logic [4:0]        upper_channel_q;
  logic signed [6:0] upper_transpose_q;

  logic   f_valid_q, f_valid_d;
  item_t  f_q;
  item_t  cls;
  logic   accept;

  logic [3:0]      mst, chn, zone_ch;
  logic            is_note, chan_ok, handle, lower;
  logic [KeyW-1:0] key;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_filter_q  <= RST_CHANNEL_FILTER;
      split_key_q       <= RST_SPLIT_KEY;
      lower_channel_q   <= RST_LOWER_CHANNEL;
      lower_transpose_q <= RST_TRANSPOSE;
      upper_channel_q   <= RST_UPPER_CHANNEL;
      upper_transpose_q <= RST_TRANSPOSE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHANNEL_FILTER:  channel_filter_q  <= cfg_wdata_i[4:0];
        CFG_SPLIT_KEY:       split_key_q       <= cfg_wdata_i;
        CFG_LOWER_CHANNEL:   lower_channel_q   <= cfg_wdata_i[4:0];
        CFG_LOWER_TRANSPOSE: lower_transpose_q <= cfg_wdata_i;
        CFG_UPPER_CHANNEL:   upper_channel_q   <= cfg_wdata_i[4:0];
        CFG_UPPER_TRANSPOSE: upper_transpose_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Classify the incoming message
  always_comb begin
    mst     = status_byte_i[7:4];
    chn     = status_byte_i[3:0];
    is_note = mst inside {NIB_NOTE_ON, NIB_NOTE_OFF, NIB_POLY_PRES};
    chan_ok = (channel_filter_q == 5'd0) || (chan_nibble(channel_filter_q) == chn);
    handle  = (msg_length_i == LEN_FULL) && is_note && chan_ok;
    key     = first_data_i[KeyW-1:0];
    lower   = key < split_key_q;
    zone_ch = lower ? chan_nibble(lower_channel_q) : chan_nibble(upper_channel_q);

    cls.time_stamp = time_stamp_i;
    cls.first      = first_data_i;
    cls.second     = second_data_i;
    cls.length     = msg_length_i;
    cls.key        = key;
    cls.transpose  = lower ? lower_transpose_q : upper_transpose_q;

    if (!handle) begin
      cls.op = OP_PASS;
    end else if (mst == NIB_NOTE_ON && second_data_i[6:0] != 7'd0) begin
      cls.op = OP_ON;
    end else if (mst == NIB_NOTE_ON || mst == NIB_NOTE_OFF) begin
      cls.op = OP_OFF;
    end else begin
      cls.op = OP_POLY;
    end

    case (cls.op)
      OP_ON:   cls.status = {NIB_NOTE_ON, zone_ch};
      OP_OFF:  cls.status = {NIB_NOTE_OFF, zone_ch};
      OP_POLY: cls.status = {NIB_POLY_PRES, zone_ch};
      default: cls.status = status_byte_i;
    endcase
  end

  // Hand off to the queue; stall while the held beat cannot move on
  assign push_o     = f_valid_q && !q_stat_i.full;
  assign in_stall_o = f_valid_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign f_valid_d  = accept || (f_valid_q && !push_o);
  assign item_o     = f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q <= cls;
    end
  end

endmodule

// ===== rtl/core/mks_queue.sv =====
// ----------------------------------------------------------------------------
// MIDI key-split router queue
// Small FIFO of classified messages between the front and back ends.
// ----------------------------------------------------------------------------
module mks_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mks_pkg::item_t  data_i,
  input  logic            pop_i,
  output mks_pkg::item_t  data_o,
  output mks_pkg::qstat_t stat_o
);
  import mks_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  item_t           entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Advance pointers and track fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);

endmodule

// ===== rtl/core/mks_back.sv =====
// ----------------------------------------------------------------------------
// MIDI key-split router back end
// Looks up the held transpose per key, computes the routed key, updates the
// held table and drives the output register.
// ----------------------------------------------------------------------------
module mks_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mks_pkg::item_t  head_i,
  input  mks_pkg::qstat_t q_stat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output mks_pkg::res_t   res_o
);
  import mks_pkg::*;

  localparam int unsigned KeyCount = 2 ** KeyW;

  logic signed [6:0] held_mem [KeyCount];
  logic [KeyCount-1:0] held_valid_q;

  item_t             b1_q;
  logic              b1_valid_q;
  logic signed [6:0] rd_q;
  logic              byp_q;
  logic signed [6:0] byp_data_q;
  logic signed [6:0] held_tr;
  logic              out_valid_q;
  res_t              res_q;
  res_t              res_d;
  logic              out_ready, b1_fire, mem_we;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign b1_fire   = b1_valid_q && out_ready;
  assign pop_o     = !q_stat_i.empty && (!b1_valid_q || out_ready);
  assign mem_we    = b1_fire && (b1_q.op == OP_ON);

  // Held transpose memory: write on note-on, registered read at pop
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      held_mem[b1_q.key] <= b1_q.transpose;
    end
    if (pop_o) begin
      rd_q <= held_mem[head_i.key];
    end
  end

  // Bypass a write to the key being read in the same cycle
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byp_q      <= mem_we && (head_i.key == b1_q.key);
      byp_data_q <= b1_q.transpose;
    end
  end

  assign held_tr = byp_q ? byp_data_q : rd_q;

  // Valid bits: set on note-on, drop on note-off
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= '0;
    end else if (b1_fire) begin
      if (b1_q.op == OP_ON) begin
        held_valid_q[b1_q.key] <= 1'b1;
      end else if (b1_q.op == OP_OFF) begin
        held_valid_q[b1_q.key] <= 1'b0;
      end
    end
  end

  // Work stage holds one message
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
    end else if (pop_o) begin
      b1_valid_q <= 1'b1;
    end else if (b1_fire) begin
      b1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b1_q <= head_i;
    end
  end

  // Compute the routed key
  always_comb begin
    res_d.time_stamp = b1_q.time_stamp;
    res_d.status     = b1_q.status;
    res_d.second     = b1_q.second;
    res_d.length     = b1_q.length;
    case (b1_q.op)
      OP_ON, OP_POLY: res_d.first = {1'b0, shift_clamp(b1_q.key, b1_q.transpose)};
      OP_OFF: begin
        res_d.first = held_valid_q[b1_q.key] ? {1'b0, shift_clamp(b1_q.key, held_tr)}
                                             : 8'd0;
      end
      default: res_d.first = b1_q.first;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b1_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/core/midi_keysplit_router_top.sv =====
// ----------------------------------------------------------------------------
// MIDI key-split router
// Routes note messages to a lower or upper zone by key, transposes the key
// and remembers each note-on's transpose for its note-off.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with one MIDI message per beat.
//   Output channel: out_valid_o / out_stall_i with exactly one result per
//   input beat, in input order.
//   Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
//   clock edge; write only while no message is in flight.
//   Path: front register, queue, work stage and output register.
//   Throughput: one message per cycle unless the receiver stalls; transpose
//   table read at pop, written from the work stage, with a same-key bypass.
//   When the receiver stalls, the output register holds its beat, the work
//   stage and the queue fill, and in_stall_o rises once the front register
//   cannot move on.
//   Reset: configuration returns to its defaults, all held notes are
//   forgotten at once, and all pipeline and queue state empties. There is no
//   clearing pass; the block takes messages as soon as reset is released.
// ----------------------------------------------------------------------------
module midi_keysplit_router_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mks_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mks_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [31:0]                  time_stamp_i,
  input  logic [7:0]                   status_byte_i,
  input  logic [7:0]                   first_data_i,
  input  logic [7:0]                   second_data_i,
  input  logic [1:0]                   msg_length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  out_time_o,
  output logic [7:0]                   out_status_o,
  output logic [7:0]                   out_first_o,
  output logic [7:0]                   out_second_o,
  output logic [1:0]                   out_length_o
);
  import mks_pkg::*;

  item_t  front_item, head_item;
  qstat_t q_stat;
  logic   q_push, q_pop;
  res_t   res;

  // Accept and classify
  mks_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .time_stamp_i,
    .status_byte_i,
    .first_data_i,
    .second_data_i,
    .msg_length_i,
    .q_stat_i (q_stat),
    .push_o   (q_push),
    .item_o   (front_item)
  );

  // Decouple front and back
  mks_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i (q_push),
    .data_i (front_item),
    .pop_i  (q_pop),
    .data_o (head_item),
    .stat_o (q_stat)
  );

  // Table lookup, key compute and output
  mks_back u_back (
    .clk_i,
    .rst_ni,
    .head_i      (head_item),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o,
    .out_stall_i,
    .res_o       (res)
  );

  assign out_time_o   = res.time_stamp;
  assign out_status_o = res.status;
  assign out_first_o  = res.first;
  assign out_second_o = res.second;
  assign out_length_o = res.length;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");
`endif

endmodule

// ===== tb/sv/midi_keysplit_router_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI key-split router testbench
// Sends MIDI messages through the router while the sender pauses and the
// receiver stalls at random. A behavioral copy of the router predicts each
// routed message, including the per-key transpose memory, and every result
// is checked field by field, in order, across several register settings.
// ----------------------------------------------------------------------------
module midi_keysplit_router_top_tb;
  import mks_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned LiveKeyMax = 12;
  localparam logic [3:0]  NIB_CTRL   = 4'hB;

  typedef struct packed {
    logic [31:0] stamp;
    logic [7:0]  status;
    logic [7:0]  data1;
    logic [7:0]  data2;
    logic [1:0]  len;
  } midi_msg_t;

  // DUT ports, all inputs known from time zero
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i    = CFG_CHANNEL_FILTER;
  logic [CfgDataW-1:0] cfg_wdata_i  = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [31:0]         time_stamp_i = '0;
  logic [7:0]          status_byte_i = '0;
  logic [7:0]          first_data_i = '0;
  logic [7:0]          second_data_i = '0;
  logic [1:0]          msg_length_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [31:0]         out_time_o;
  logic [7:0]          out_status_o;
  logic [7:0]          out_first_o;
  logic [7:0]          out_second_o;
  logic [1:0]          out_length_o;

  // Register shadow of the router
  logic [4:0]        flt_cfg     = RST_CHANNEL_FILTER;
  logic [6:0]        split_cfg   = RST_SPLIT_KEY;
  logic [4:0]        lo_chan_cfg = RST_LOWER_CHANNEL;
  logic signed [6:0] lo_ofs_cfg  = RST_TRANSPOSE;
  logic [4:0]        hi_chan_cfg = RST_UPPER_CHANNEL;
  logic signed [6:0] hi_ofs_cfg  = RST_TRANSPOSE;

  // Per-key transpose memory, clear from time zero
  bit held_ok  [0:127];
  int held_ofs [0:127];

  midi_msg_t   midi_in_q [$];
  midi_msg_t   routed_q  [$];
  logic [7:0]  live_keys [$];
  midi_msg_t   cur_msg = '0;
  bit          presenting = 1'b0;
  bit          beat_taken = 1'b0;
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;

  midi_keysplit_router_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .time_stamp_i  (time_stamp_i),
    .status_byte_i (status_byte_i),
    .first_data_i  (first_data_i),
    .second_data_i (second_data_i),
    .msg_length_i  (msg_length_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_time_o    (out_time_o),
    .out_status_o  (out_status_o),
    .out_first_o   (out_first_o),
    .out_second_o  (out_second_o),
    .out_length_o  (out_length_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // 1-based channel register to status nibble; 0 acts as 1, above 16 as 16
  function automatic logic [3:0] to_nibble(input logic [4:0] c);
    return (c == 5'd0) ? 4'd0 : (c >= 5'd16) ? 4'd15 : c[3:0] - 4'd1;
  endfunction

  function automatic logic [7:0] clip_key(input int v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 127) begin
      return 8'd127;
    end
    return v[7:0];
  endfunction

  // Route one message and update the transpose memory
  function automatic midi_msg_t route_note(input midi_msg_t m);
    midi_msg_t  r;
    logic [3:0] kind;
    logic [6:0] key;
    logic       lower;
    int         ofs;
    r = m;
    kind = m.status[7:4];
    if (m.len == LEN_FULL &&
        (kind == NIB_NOTE_ON || kind == NIB_NOTE_OFF || kind == NIB_POLY_PRES) &&
        (flt_cfg == 5'd0 || to_nibble(flt_cfg) == m.status[3:0])) begin
      key = m.data1[6:0];
      lower = (key < split_cfg);
      ofs = lower ? int'(lo_ofs_cfg) : int'(hi_ofs_cfg);
      // zero velocity turns a note-on into a note-off
      if (kind == NIB_NOTE_ON && m.data2[6:0] == 7'd0) begin
        kind = NIB_NOTE_OFF;
      end
      case (kind)
        NIB_NOTE_ON: begin
          held_ok[key] = 1'b1;
          held_ofs[key] = ofs;
          r.data1 = clip_key(int'(key) + ofs);
        end
        NIB_NOTE_OFF: begin
          r.data1 = held_ok[key] ? clip_key(int'(key) + held_ofs[key]) : 8'd0;
          held_ok[key] = 1'b0;
          held_ofs[key] = 0;
        end
        default: begin
          r.data1 = clip_key(int'(key) + ofs);
        end
      endcase
      r.status = {kind, lower ? to_nibble(lo_chan_cfg) : to_nibble(hi_chan_cfg)};
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  // Sample register writes, input beats and result beats
  always @(posedge clk_i) begin : monitor
    midi_msg_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CHANNEL_FILTER:  flt_cfg = cfg_wdata_i[4:0];
          CFG_SPLIT_KEY:       split_cfg = cfg_wdata_i[6:0];
          CFG_LOWER_CHANNEL:   lo_chan_cfg = cfg_wdata_i[4:0];
          CFG_LOWER_TRANSPOSE: lo_ofs_cfg = cfg_wdata_i[6:0];
          CFG_UPPER_CHANNEL:   hi_chan_cfg = cfg_wdata_i[4:0];
          CFG_UPPER_TRANSPOSE: hi_ofs_cfg = cfg_wdata_i[6:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        routed_q.push_back(route_note({time_stamp_i, status_byte_i, first_data_i,
                                       second_data_i, msg_length_i}));
        beat_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (routed_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: result beat with nothing expected, actual status 0x%0h",
                   $time, out_status_o);
        end else begin
          want = routed_q.pop_front();
          check_field("out_time", want.stamp, out_time_o);
          check_field("out_status", {24'd0, want.status}, {24'd0, out_status_o});
          check_field("out_first", {24'd0, want.data1}, {24'd0, out_first_o});
          check_field("out_second", {24'd0, want.data2}, {24'd0, out_second_o});
          check_field("out_length", {30'd0, want.len}, {30'd0, out_length_o});
        end
      end
    end
  end

  // Hold the current beat until taken, then advance with random gaps
  always @(negedge clk_i) begin : driver
    if (beat_taken) begin
      presenting = 1'b0;
      beat_taken = 1'b0;
    end
    if (!presenting && midi_in_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
      cur_msg = midi_in_q.pop_front();
      presenting = 1'b1;
    end
    in_valid_i    <= presenting;
    time_stamp_i  <= cur_msg.stamp;
    status_byte_i <= cur_msg.status;
    first_data_i  <= cur_msg.data1;
    second_data_i <= cur_msg.data2;
    msg_length_i  <= cur_msg.len;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_msg(input logic [7:0] st, input logic [7:0] d1,
                           input logic [7:0] d2, input logic [1:0] len);
    midi_msg_t m;
    m.stamp = $urandom;
    m.status = st;
    m.data1 = d1;
    m.data2 = d2;
    m.len = len;
    midi_in_q.push_back(m);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val[6:0];
  endtask

  task automatic load_regs(input int flt, input int split, input int lo_ch, input int lo_tr,
                           input int hi_ch, input int hi_tr);
    write_reg(CFG_CHANNEL_FILTER, flt);
    write_reg(CFG_SPLIT_KEY, split);
    write_reg(CFG_LOWER_CHANNEL, lo_ch);
    write_reg(CFG_LOWER_TRANSPOSE, lo_tr);
    write_reg(CFG_UPPER_CHANNEL, hi_ch);
    write_reg(CFG_UPPER_TRANSPOSE, hi_tr);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Wait until every queued beat is sent and every result has come back
  task automatic drain();
    while (midi_in_q.size() > 0 || presenting || routed_q.size() > 0) begin
      @(negedge clk_i);
    end
    repeat (TailCycles) @(negedge clk_i);
  endtask

  // Mostly note-on / note-off pairs on live keys, plus pressure and noise
  task automatic queue_random(input int n);
    logic [7:0]  key;
    logic [7:0]  vel;
    logic [3:0]  chan;
    logic [1:0]  len;
    int unsigned sel;
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      key = 8'($urandom_range(255));
      vel = 8'($urandom_range(255));
      if (flt_cfg != 5'd0 && $urandom_range(7) != 0) begin
        chan = to_nibble(flt_cfg);
      end else begin
        chan = 4'($urandom_range(15));
      end
      if (sel < 35) begin
        queue_msg({NIB_NOTE_ON, chan}, key, vel, LEN_FULL);
        live_keys.push_back(key);
        if (live_keys.size() > LiveKeyMax) begin
          live_keys.delete(0);
        end
      end else if (sel < 60 && live_keys.size() > 0) begin
        pick = $urandom_range(live_keys.size() - 1);
        key = live_keys[pick] ^ {1'($urandom_range(1)), 7'd0};
        live_keys.delete(pick);
        if (sel < 45) begin
          queue_msg({NIB_NOTE_ON, chan}, key, {vel[7], 7'd0}, LEN_FULL);
        end else begin
          queue_msg({NIB_NOTE_OFF, chan}, key, vel, LEN_FULL);
        end
      end else if (sel < 72) begin
        queue_msg({NIB_POLY_PRES, chan}, key, vel, LEN_FULL);
      end else if (sel < 84) begin
        // short note messages pass through untouched
        len = 2'($urandom_range(2));
        case ($urandom_range(2))
          0:       queue_msg({NIB_NOTE_ON, chan}, key, vel, len);
          1:       queue_msg({NIB_NOTE_OFF, chan}, key, vel, len);
          default: queue_msg({NIB_POLY_PRES, chan}, key, vel, len);
        endcase
      end else begin
        queue_msg(8'($urandom_range(255)), key, vel, 2'($urandom_range(3)));
      end
    end
  endtask

  initial begin : stimulus
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Sender rarely idles, receiver stalls often
    send_gap_pct = 7;
    stall_pct = 58;
    load_regs(0, 60, 3, -48, 16, 48);
    // zone edges and clamping at both ends
    queue_msg({NIB_NOTE_ON, 4'd0}, 8'd0, 8'h7F, LEN_FULL);
    queue_msg({NIB_NOTE_ON, 4'd9}, 8'd127, 8'd1, LEN_FULL);
    queue_msg({NIB_NOTE_ON, 4'd15}, 8'd59, 8'd64, LEN_FULL);
    queue_msg({NIB_NOTE_ON, 4'd3}, 8'd60, 8'd64, LEN_FULL);
    // key top bit is ignored
    queue_msg({NIB_POLY_PRES, 4'd1}, 8'hC8, 8'h55, LEN_FULL);
    // note-offs use the remembered transpose
    queue_msg({NIB_NOTE_OFF, 4'd0}, 8'd0, 8'd0, LEN_FULL);
    queue_msg({NIB_NOTE_OFF, 4'd2}, 8'd59, 8'hFF, LEN_FULL);
    queue_msg({NIB_NOTE_OFF, 4'd7}, 8'd60, 8'h40, LEN_FULL);
    // zero velocity note-on on a cleared key, velocity top bit ignored
    queue_msg({NIB_NOTE_ON, 4'd4}, 8'h8A, 8'h80, LEN_FULL);
    queue_msg({NIB_NOTE_OFF, 4'd4}, 8'd5, 8'd10, LEN_FULL);
    queue_msg({NIB_NOTE_ON, 4'd4}, 8'd70, 8'd0, LEN_FULL);
    // short and foreign messages pass through
    queue_msg({NIB_NOTE_ON, 4'd0}, 8'd40, 8'd90, 2'd2);
    queue_msg({NIB_NOTE_OFF, 4'd0}, 8'd40, 8'd90, 2'd1);
    queue_msg({NIB_NOTE_ON, 4'd0}, 8'hFF, 8'hFF, 2'd0);
    queue_msg({NIB_CTRL, 4'd5}, 8'd7, 8'd100, LEN_FULL);
    queue_msg(8'hFF, 8'hFF, 8'hFF, LEN_FULL);
    queue_msg(8'h00, 8'h00, 8'h00, LEN_FULL);
    // notes left held across the next register change
    queue_msg({NIB_NOTE_ON, 4'd4}, 8'd100, 8'd90, LEN_FULL);
    queue_msg({NIB_NOTE_ON, 4'd4}, 8'd30, 8'd90, LEN_FULL);
    queue_msg({NIB_NOTE_ON, 4'd4}, 8'd127, 8'd90, LEN_FULL);
    queue_random(50);
    drain();
    queue_random(50);
    drain();

    // Sender idles often, receiver rarely stalls; channel filter on
    send_gap_pct = 58;
    stall_pct = 7;
    load_regs(5, 0, 0, -64, 31, 63);
    queue_msg({NIB_NOTE_OFF, 4'd4}, 8'd100, 8'd0, LEN_FULL);
    queue_msg({NIB_NOTE_OFF, 4'd4}, 8'd30, 8'd0, LEN_FULL);
    queue_msg({NIB_NOTE_OFF, 4'd5}, 8'd127, 8'd0, LEN_FULL);
    queue_msg({NIB_NOTE_OFF, 4'd4}, 8'd127, 8'd0, LEN_FULL);
    queue_msg({NIB_NOTE_ON, 4'd4}, 8'd64, 8'd1, LEN_FULL);
    queue_msg({NIB_POLY_PRES, 4'd4}, 8'd0, 8'd1, LEN_FULL);
    queue_random(100);
    drain();

    // No gaps, no stalls; out-of-range filter and lower channel
    send_gap_pct = 0;
    stall_pct = 0;
    load_regs(31, 127, 17, 63, 1, -64);
    queue_random(100);
    drain();

    load_regs($urandom_range(16), $urandom_range(127), $urandom_range(16, 1),
              $urandom_range(127), $urandom_range(16, 1), $urandom_range(127));
    queue_random(100);
    drain();

    if (err_cnt == 0 && routed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/mks_pkg.sv
rtl/core/mks_front.sv
rtl/core/mks_queue.sv
rtl/core/mks_back.sv
rtl/core/midi_keysplit_router_top.sv
tb/sv/midi_keysplit_router_top_tb.sv
